### src/mmc_pkg.sv
// Shared types, constants and helpers for the pairwise mismatch counter.
// Used by mmc_column, mmc_counts and msa_pairwise_mismatch_counter_core.
// No dependencies.
package mmc_pkg;

    // Array geometry.
    localparam int MAX_SEQS  = 16;
    localparam int POS_W     = $clog2(MAX_SEQS);
    localparam int NUM_PAIRS = MAX_SEQS * (MAX_SEQS - 1) / 2;
    localparam int COUNT_W   = 16;
    localparam int CHAR_W    = 8;
    localparam int SEQ_CNT_W = 5;
    localparam int DIST_W    = 16;

    // Sequence count after reset.
    localparam logic [SEQ_CNT_W-1:0] SEQ_COUNT_RESET = SEQ_CNT_W'(16);

    // Nucleotide letters, both cases.
    localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC = 8'h63;
    localparam logic [CHAR_W-1:0] CH_LG = 8'h67;
    localparam logic [CHAR_W-1:0] CH_LT = 8'h74;
    localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC = 8'h43;
    localparam logic [CHAR_W-1:0] CH_UG = 8'h47;
    localparam logic [CHAR_W-1:0] CH_UT = 8'h54;

    // Item function codes; the fourth code is unused and ignored.
    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    // Update command from the column logic to the counter cells.
    typedef struct packed {
        logic                 clr;
        logic [NUM_PAIRS-1:0] diff;
    } t_upd;

    // Flat position of pair (i, j), i < j, in upper-triangle row order.
    function automatic int pair_index(input int i, input int j);
        return i * (2 * MAX_SEQS - i - 1) / 2 + (j - i - 1);
    endfunction

    // True for one of acgtACGT.
    function automatic logic is_base(input logic [CHAR_W-1:0] c);
        return c inside {CH_LA, CH_LC, CH_LG, CH_LT, CH_UA, CH_UC, CH_UG, CH_UT};
    endfunction

endpackage

### src/mmc_column.sv
// Column buffer, column position and end-of-column evaluation.
// Produces the per-pair increment vector and the clear command.
// Depends on mmc_pkg.
module mmc_column (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  mmc_pkg::t_func                i_func,
    input  logic [mmc_pkg::CHAR_W-1:0]    i_char,
    input  logic [mmc_pkg::SEQ_CNT_W-1:0] i_seq_count,
    output mmc_pkg::t_upd                 o_upd
);

    logic [mmc_pkg::CHAR_W-1:0] r_buf [mmc_pkg::MAX_SEQS];
    logic [mmc_pkg::POS_W-1:0]  r_pos;
    logic [mmc_pkg::POS_W-1:0]  n_pos;
    logic [mmc_pkg::POS_W-1:0]  last;
    logic [mmc_pkg::POS_W-1:0]  wpos;
    logic                       push;
    logic                       finish;
    logic                       all_ok;
    logic                       differs;
    logic                       keep;
    logic [mmc_pkg::CHAR_W-1:0] chars [mmc_pkg::MAX_SEQS];

    // Index of the last sequence, from the count clamped to 2..MAX_SEQS.
    always_comb begin
        if (i_seq_count < mmc_pkg::SEQ_CNT_W'(2)) begin
            last = mmc_pkg::POS_W'(1);
        end else if (i_seq_count > mmc_pkg::SEQ_CNT_W'(mmc_pkg::MAX_SEQS)) begin
            last = mmc_pkg::POS_W'(mmc_pkg::MAX_SEQS - 1);
        end else begin
            last = mmc_pkg::POS_W'(i_seq_count - mmc_pkg::SEQ_CNT_W'(1));
        end
    end

    // A push at or past the last position closes the column there.
    assign push   = i_en && (i_func == mmc_pkg::FUNC_PUSH);
    assign finish = push && (r_pos >= last);
    assign wpos   = finish ? last : r_pos;

    // Column as it stands once this beat is stored.
    always_comb begin
        for (int k = 0; k < mmc_pkg::MAX_SEQS; k++) begin
            chars[k] = (mmc_pkg::POS_W'(k) == last) ? i_char : r_buf[k];
        end
    end

    // Alphabet check and all-equal check over the active sequences.
    always_comb begin
        all_ok  = 1'b1;
        differs = 1'b0;
        for (int k = 0; k < mmc_pkg::MAX_SEQS; k++) begin
            if (mmc_pkg::POS_W'(k) <= last) begin
                if (!mmc_pkg::is_base(chars[k])) begin
                    all_ok = 1'b0;
                end
                if (chars[k] != chars[0]) begin
                    differs = 1'b1;
                end
            end
        end
    end

    assign keep = finish && all_ok && differs;

    // One comparator per pair of active sequences, plus the clear command.
    always_comb begin
        o_upd.clr  = i_en && (i_func == mmc_pkg::FUNC_CLEAR);
        o_upd.diff = '0;
        for (int i = 0; i < mmc_pkg::MAX_SEQS; i++) begin
            for (int j = i + 1; j < mmc_pkg::MAX_SEQS; j++) begin
                o_upd.diff[mmc_pkg::pair_index(i, j)] =
                    keep && (mmc_pkg::POS_W'(j) <= last) && (chars[i] != chars[j]);
            end
        end
    end

    // Buffer write; entries carry no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[wpos] <= i_char;
        end
    end

    // Column position.
    always_comb begin
        n_pos = r_pos;
        if (o_upd.clr || finish) begin
            n_pos = '0;
        end else if (push) begin
            n_pos = r_pos + mmc_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // A closed or cleared column restarts at the first sequence.
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish || o_upd.clr) |=> (r_pos == '0))
        else $error("column position not restarted");

    // Counts change only for a column that was closed in the same beat.
    a_diff_only_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_upd.diff != '0) |-> finish)
        else $error("pair increment outside a column close");

endmodule

### src/mmc_counts.sv
// Saturating mismatch counters, one cell per sequence pair, and the pair read mux.
// Depends on mmc_pkg.
module mmc_counts (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mmc_pkg::t_upd              i_upd,
    input  logic [mmc_pkg::POS_W-1:0]  i_row,
    input  logic [mmc_pkg::POS_W-1:0]  i_col,
    output logic [mmc_pkg::DIST_W-1:0] o_rd_data
);

    logic [mmc_pkg::COUNT_W-1:0] r_cnt [mmc_pkg::NUM_PAIRS];
    logic [mmc_pkg::COUNT_W-1:0] rd;

    // Counter cells: clear all, or step each flagged pair up to its maximum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < mmc_pkg::NUM_PAIRS; p++) begin
                r_cnt[p] <= '0;
            end
        end else if (i_upd.clr) begin
            for (int p = 0; p < mmc_pkg::NUM_PAIRS; p++) begin
                r_cnt[p] <= '0;
            end
        end else begin
            for (int p = 0; p < mmc_pkg::NUM_PAIRS; p++) begin
                if (i_upd.diff[p] && (r_cnt[p] != '1)) begin
                    r_cnt[p] <= r_cnt[p] + mmc_pkg::COUNT_W'(1);
                end
            end
        end
    end

    // Pair select; a row not below the column reads zero.
    always_comb begin
        rd = '0;
        for (int i = 0; i < mmc_pkg::MAX_SEQS; i++) begin
            for (int j = i + 1; j < mmc_pkg::MAX_SEQS; j++) begin
                if ((i_row == mmc_pkg::POS_W'(i)) && (i_col == mmc_pkg::POS_W'(j))) begin
                    rd = r_cnt[mmc_pkg::pair_index(i, j)];
                end
            end
        end
    end

    assign o_rd_data = rd[mmc_pkg::DIST_W-1:0];

    // After a clear every pair reads zero.
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd.clr |=> (o_rd_data == '0))
        else $error("count not zero after clear");

endmodule

### src/msa_pairwise_mismatch_counter_core.sv
// Top level of the pairwise mismatch counter: stream ports, input and result registers.
// Depends on mmc_pkg, mmc_column and mmc_counts.
//
// The block takes one beat per clock cycle. Each beat is held in an input register and
// processed from there by one pass of logic: pushes fill the column buffer and,
// on the last sequence of a column, update all pair counters in parallel; reads select one
// counter; clears zero the counters and the column position. A read result reaches the
// master side from a result register and sits there, so the slave side keeps accepting
// while a result waits. Only a read that finds the result register still full and not
// taken holds the input back. Counters are in flip-flops and clear at reset, so there
// is no start-up sweep.
module msa_pairwise_mismatch_counter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration: sequence count.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mmc_pkg::SEQ_CNT_W-1:0] i_cfg_data,
    // Input stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata fields from bit 0: base_char[7:0], pair_row[11:8], pair_col[15:12].
    input  logic [15:0]                   s_axis_tdata,
    input  logic [1:0]                    s_axis_tuser,  // func[1:0]
    // Result stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata   // distance[15:0]
);

    logic [mmc_pkg::SEQ_CNT_W-1:0] r_seq_count;
    logic                          r_s1_valid;
    mmc_pkg::t_func                r_s1_func;
    logic [mmc_pkg::CHAR_W-1:0]    r_s1_char;
    logic [mmc_pkg::POS_W-1:0]     r_s1_row;
    logic [mmc_pkg::POS_W-1:0]     r_s1_col;
    logic                          r_out_valid;
    logic [mmc_pkg::DIST_W-1:0]    r_out_data;
    logic                          s_accept;
    logic                          s1_is_read;
    logic                          s1_adv;
    logic                          s1_en;
    mmc_pkg::t_upd                 upd;
    logic [mmc_pkg::DIST_W-1:0]    rd_data;

    // Config register: the user writes it only while the block is idle; not enforced here.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_count <= mmc_pkg::SEQ_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_seq_count <= i_cfg_data;
        end
    end

    // Stage advance: only a read waits for room in the result register.
    assign s1_is_read    = (r_s1_func == mmc_pkg::FUNC_READ);
    assign s1_adv        = !s1_is_read || !r_out_valid || m_axis_tready;
    assign s1_en         = r_s1_valid && s1_adv;
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_func <= mmc_pkg::t_func'(s_axis_tuser);
            r_s1_char <= s_axis_tdata[7:0];
            r_s1_row  <= s_axis_tdata[11:8];
            r_s1_col  <= s_axis_tdata[15:12];
        end
    end

    mmc_column u_column (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (s1_en),
        .i_func      (r_s1_func),
        .i_char      (r_s1_char),
        .i_seq_count (r_seq_count),
        .o_upd       (upd)
    );

    mmc_counts u_counts (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (upd),
        .i_row     (r_s1_row),
        .i_col     (r_s1_col),
        .o_rd_data (rd_data)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_en && s1_is_read) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en && s1_is_read) begin
            r_out_data <= rd_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A read leaving the input register always lands in the result register.
    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_en && s1_is_read) |=> m_axis_tvalid)
        else $error("read did not produce a result");

    // No result appears without a read behind it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(s1_en && s1_is_read)) |=> !m_axis_tvalid)
        else $error("result without a read");

    // Input is held back only by a read stalled on a full result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_valid && s1_is_read && r_out_valid && !m_axis_tready))
        else $error("input stalled without cause");

endmodule

### tb/tb_msa_pairwise_mismatch_counter_core.sv
// Self-checking testbench for msa_pairwise_mismatch_counter_core.
// Depends on mmc_pkg and the core. A queue-fed driver sends pushes, reads and clears, and
// a clocked monitor checks every read result against pair counters kept in the bench.
module tb_msa_pairwise_mismatch_counter_core;

    // The fourth function code has no name in the package; the block ignores it.
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int QUEUE_HIGH   = 32;
    localparam int PHASE_BEATS  = 24;
    localparam logic [mmc_pkg::COUNT_W-1:0] COUNT_TOP = '1;

    typedef struct {
        logic [1:0]                 func;
        logic [mmc_pkg::CHAR_W-1:0] ch;
        logic [mmc_pkg::POS_W-1:0]  row;
        logic [mmc_pkg::POS_W-1:0]  col;
    } t_beat;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [mmc_pkg::SEQ_CNT_W-1:0] i_cfg_data    = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // tdata fields from bit 0: base_char[7:0], pair_row[11:8], pair_col[15:12].
    logic [15:0]                   s_axis_tdata  = '0;
    logic [1:0]                    s_axis_tuser  = '0;  // func[1:0]
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [15:0]                   m_axis_tdata;        // distance[15:0]

    // Beats waiting for the driver and distances waiting for the monitor.
    t_beat                      pending_beats[$];
    logic [mmc_pkg::DIST_W-1:0] expected_dist[$];
    int                         error_count = 0;
    int                         idle_cycles = 0;

    // Bench copy of the block state.
    logic [mmc_pkg::SEQ_CNT_W-1:0] model_seq_count;
    logic [mmc_pkg::CHAR_W-1:0]    model_column[mmc_pkg::MAX_SEQS];
    int                            model_fill;
    logic [mmc_pkg::COUNT_W-1:0]   model_tally[mmc_pkg::MAX_SEQS][mmc_pkg::MAX_SEQS];

    // Stimulus side view of sequence count and column position.
    int gen_seqs;
    int gen_fill;
    int phase_beats;
    bit calm = 1'b0;

    // Handshake state shared between the clocked blocks.
    bit in_fire  = 1'b0;
    bit drv_busy = 1'b0;
    int send_gap = 0;
    int sink_hold = 0;

    msa_pairwise_mismatch_counter_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Sequence counts outside 2..MAX_SEQS behave as the nearest bound.
    function automatic int clamp_seqs(input int v);
        if (v < 2) return 2;
        if (v > mmc_pkg::MAX_SEQS) return mmc_pkg::MAX_SEQS;
        return v;
    endfunction

    function automatic bit is_nucleotide(input logic [mmc_pkg::CHAR_W-1:0] c);
        case (c)
            mmc_pkg::CH_LA, mmc_pkg::CH_LC, mmc_pkg::CH_LG, mmc_pkg::CH_LT,
            mmc_pkg::CH_UA, mmc_pkg::CH_UC, mmc_pkg::CH_UG, mmc_pkg::CH_UT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [mmc_pkg::CHAR_W-1:0] random_base();
        case ($urandom_range(0, 7))
            0: return mmc_pkg::CH_LA;
            1: return mmc_pkg::CH_LC;
            2: return mmc_pkg::CH_LG;
            3: return mmc_pkg::CH_LT;
            4: return mmc_pkg::CH_UA;
            5: return mmc_pkg::CH_UC;
            6: return mmc_pkg::CH_UG;
            default: return mmc_pkg::CH_UT;
        endcase
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // A finished column counts only if it is all nucleotides and not uniform.
    task automatic tally_column(input int n);
        bit all_bases;
        bit mixed;
        all_bases = 1'b1;
        mixed     = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!is_nucleotide(model_column[i])) all_bases = 1'b0;
            if (model_column[i] != model_column[0]) mixed = 1'b1;
        end
        if (all_bases && mixed) begin
            for (int i = 0; i < n; i++) begin
                for (int j = i + 1; j < n; j++) begin
                    if (model_column[i] != model_column[j] && model_tally[i][j] != COUNT_TOP)
                        model_tally[i][j]++;
                end
            end
        end
    endtask

    // Update the bench state for one accepted beat and queue any distance it yields.
    task automatic predict_beat(input t_beat b);
        int n;
        n = clamp_seqs(model_seq_count);
        case (b.func)
            mmc_pkg::FUNC_PUSH: begin
                // A position at or past the last slot closes the column there.
                if (model_fill >= n - 1) begin
                    model_column[n - 1] = b.ch;
                    tally_column(n);
                    model_fill = 0;
                end else begin
                    model_column[model_fill] = b.ch;
                    model_fill++;
                end
            end
            mmc_pkg::FUNC_READ: begin
                if (b.row < b.col)
                    expected_dist.insert(expected_dist.size(), model_tally[b.row][b.col]);
                else
                    expected_dist.insert(expected_dist.size(), '0);
            end
            mmc_pkg::FUNC_CLEAR: begin
                foreach (model_tally[i, j]) model_tally[i][j] = '0;
                model_fill = 0;
            end
            default: ;
        endcase
    endtask

    // Queue one beat, holding back when the driver is well supplied.
    task automatic add_beat(input logic [1:0] func, input logic [mmc_pkg::CHAR_W-1:0] ch,
                            input logic [mmc_pkg::POS_W-1:0] row,
                            input logic [mmc_pkg::POS_W-1:0] col);
        t_beat b;
        while (pending_beats.size() >= QUEUE_HIGH) @(negedge i_clk);
        b.func = func;
        b.ch   = ch;
        b.row  = row;
        b.col  = col;
        pending_beats.insert(pending_beats.size(), b);
        if (func == mmc_pkg::FUNC_PUSH) gen_fill = (gen_fill >= gen_seqs - 1) ? 0 : gen_fill + 1;
        else if (func == mmc_pkg::FUNC_CLEAR) gen_fill = 0;
        if (func != FUNC_SPARE) phase_beats++;
    endtask

    task automatic push_char(input logic [mmc_pkg::CHAR_W-1:0] ch);
        add_beat(mmc_pkg::FUNC_PUSH, ch, mmc_pkg::POS_W'($urandom), mmc_pkg::POS_W'($urandom));
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    task automatic read_pair(input int row, input int col);
        add_beat(mmc_pkg::FUNC_READ, mmc_pkg::CHAR_W'($urandom),
                 mmc_pkg::POS_W'(row), mmc_pkg::POS_W'(col));
    endtask

    task automatic clear_counts();
        add_beat(mmc_pkg::FUNC_CLEAR, mmc_pkg::CHAR_W'($urandom),
                 mmc_pkg::POS_W'($urandom), mmc_pkg::POS_W'($urandom));
    endtask

    task automatic spare_beat();
        add_beat(FUNC_SPARE, mmc_pkg::CHAR_W'($urandom),
                 mmc_pkg::POS_W'($urandom), mmc_pkg::POS_W'($urandom));
    endtask

    // Wait until every beat is sent and every distance has come back, then let the
    // last push or clear work its way through.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || drv_busy || expected_dist.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_seq_count(input logic [mmc_pkg::SEQ_CNT_W-1:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        gen_seqs = clamp_seqs(v);
    endtask

    // One random operation; columns are mostly well formed with random content.
    task automatic random_op();
        int                         pick;
        int                         bad_at;
        int                         slot;
        int                         r;
        bit                         flat;
        logic [mmc_pkg::CHAR_W-1:0] same;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            bad_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, gen_seqs - 1) : -1;
            flat   = ($urandom_range(0, 7) == 0);
            same   = random_base();
            do begin
                slot = (gen_fill >= gen_seqs - 1) ? gen_seqs - 1 : gen_fill;
                if (slot == bad_at) push_char(mmc_pkg::CHAR_W'($urandom));
                else push_char(flat ? same : random_base());
            end while (gen_fill != 0);
        end else if (pick < 85) begin
            if ($urandom_range(0, 3) == 0) begin
                read_pair($urandom_range(0, 15), $urandom_range(0, 15));
            end else begin
                r = $urandom_range(0, gen_seqs - 2);
                read_pair(r, $urandom_range(r + 1, gen_seqs - 1));
            end
        end else if (pick < 92) begin
            push_char(mmc_pkg::CHAR_W'($urandom));
        end else if (pick < 96) begin
            clear_counts();
        end else begin
            spare_beat();
        end
    endtask

    // Input driver: presents the next queued beat once the current one is taken.
    always @(negedge i_clk) begin : sender
        t_beat b;
        if (!s_axis_tvalid || in_fire) begin
            if (send_gap == 0 && pending_beats.size() != 0) begin
                b = pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {b.col, b.row, b.ch};
                s_axis_tuser  <= b.func;
                drv_busy = 1'b1;
                send_gap = pick_gap();
            end else begin
                if (send_gap > 0) send_gap--;
                s_axis_tvalid <= 1'b0;
                drv_busy = 1'b0;
            end
        end
    end

    // Result receiver: ready in runs, with stalls of random length between them.
    always @(negedge i_clk) begin : receiver
        if (sink_hold > 0) begin
            sink_hold--;
        end else if (calm || $urandom_range(0, 2) != 0) begin
            m_axis_tready <= 1'b1;
            sink_hold = $urandom_range(0, 6);
        end else begin
            m_axis_tready <= 1'b0;
            sink_hold = pick_gap();
        end
    end

    // Monitor: checks results first, then folds in config and input beats; also the watchdog.
    always @(posedge i_clk) begin : monitor
        t_beat                      b;
        logic [mmc_pkg::DIST_W-1:0] want;
        bit                         out_fire;
        bit                         cfg_fire;
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            out_fire = (m_axis_tvalid === 1'b1) && m_axis_tready;
            cfg_fire = i_cfg_valid && (o_cfg_ready === 1'b1);
            if (out_fire) begin
                if (expected_dist.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no read waiting", m_axis_tdata));
                end else begin
                    want = expected_dist.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch($sformatf("distance %0d, expected %0d",
                                                  m_axis_tdata, want));
                end
            end
            if (cfg_fire) model_seq_count = i_cfg_data;
            if (in_fire) begin
                b.func = s_axis_tuser;
                b.ch   = s_axis_tdata[7:0];
                b.row  = s_axis_tdata[11:8];
                b.col  = s_axis_tdata[15:12];
                predict_beat(b);
            end
            if (in_fire || out_fire || cfg_fire) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin : stimulus
        int cfg_plan[$];
        model_seq_count = mmc_pkg::SEQ_COUNT_RESET;
        model_fill      = 0;
        foreach (model_column[i]) model_column[i] = '0;
        foreach (model_tally[i, j]) model_tally[i][j] = '0;
        gen_seqs = clamp_seqs(mmc_pkg::SEQ_COUNT_RESET);
        gen_fill = 0;
        cfg_plan = '{0, 1, 2, 3, 4, 5, 8, 16, 17, 31};
        repeat (3) cfg_plan.insert(cfg_plan.size(), $urandom_range(0, 31));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reads of an empty array, including row not below column.
        read_pair(0, 1);
        read_pair(15, 15);
        read_pair(15, 0);
        read_pair(0, 15);

        // Three sequences: a kept column, a uniform one, one with a foreign
        // character, and one where case alone makes the letters differ.
        set_seq_count(3);
        push_text("ACA");
        push_text("ccc");
        push_char(mmc_pkg::CH_UA);
        push_char(8'hFF);
        push_char(mmc_pkg::CH_UC);
        push_text("aAt");
        read_pair(0, 1);
        read_pair(0, 2);
        read_pair(1, 2);
        read_pair(2, 1);
        read_pair(0, 5);
        spare_beat();

        // Count lowered with the column position past the new last slot.
        push_text("GT");
        set_seq_count(2);
        push_char(mmc_pkg::CH_UA);
        read_pair(0, 1);
        clear_counts();
        read_pair(0, 1);

        // Random phases over a spread of sequence counts, the extremes among them.
        foreach (cfg_plan[p]) begin
            set_seq_count(mmc_pkg::SEQ_CNT_W'(cfg_plan[p]));
            calm = (p % 4 == 3);
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS) random_op();
        end
        calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

### msa_pairwise_mismatch_counter_core.f
src/mmc_pkg.sv
src/mmc_column.sv
src/mmc_counts.sv
src/msa_pairwise_mismatch_counter_core.sv
tb/tb_msa_pairwise_mismatch_counter_core.sv
